FILE: sv/assert_macros.svh
// Assertion macros shared by the interval queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every clock edge outside reset.
`define BISQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define BISQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BISQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bisq_pkg.sv
// Types, codes and constants of the Boolean interval signal queue.
package bisq_pkg;

  // Default sizing
  localparam int unsigned RING_DEPTH_DEF = 16;
  localparam int unsigned TIME_BITS_DEF  = 32;

  // Port field widths
  localparam int unsigned FIELD_BITS     = 32;
  localparam int unsigned CNT_OUT_BITS   = 5;
  localparam int unsigned IN_TDATA_BITS  = 64;
  localparam int unsigned IN_TUSER_BITS  = 2;
  localparam int unsigned OUT_TDATA_BITS = 200;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_ADD     = 2'd0,
    REQ_ADVANCE = 2'd1,
    REQ_EXTEND  = 2'd2,
    REQ_RESET   = 2'd3
  } req_e;

  // Result status
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  // Input item payload, first field in the low bits
  typedef struct packed {
    logic [FIELD_BITS-1:0] value_b;
    logic [FIELD_BITS-1:0] value_a;
  } in_item_t;

  // Result item payload, first field in the low bits, one pad bit on top
  typedef struct packed {
    logic                    pad;
    logic [FIELD_BITS-1:0]   back_right;
    logic [FIELD_BITS-1:0]   back_left;
    logic [FIELD_BITS-1:0]   front_right;
    logic [FIELD_BITS-1:0]   front_left;
    logic [CNT_OUT_BITS-1:0] interval_count;
    logic [FIELD_BITS-1:0]   domain_end;
    logic [FIELD_BITS-1:0]   domain_start;
    status_e                 status;
  } out_item_t;

endpackage

FILE: sv/boolean_interval_signal_queue.sv
// Boolean interval signal queue: domain registers, interval ring and request sequencer.
// Each request walks sequencer steps to ST_DONE: add checks start, end, emptiness, order and
// gap before a push or merge; advance is rejected, empties the domain, or pops and clips.
// One request at a time: all steps share one magnitude comparator, a pop costs a ring
// read turnaround. Next item is taken the cycle after the result is registered.
// rst_ni (async, active low) clears domain, ring pointers and sequencer; ring RAM is not
// cleared, entries beyond the count are never reported.
`include "assert_macros.svh"

module boolean_interval_signal_queue
  import bisq_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
  parameter int unsigned TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // value_a [31:0], value_b [63:32]
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  // req_type [1:0]
  input  logic [IN_TUSER_BITS-1:0]  s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // status [1:0], domain_start [33:2], domain_end [65:34], interval_count [70:66],
  // front_left [102:71], front_right [134:103], back_left [166:135],
  // back_right [198:167], zero pad [199]
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

  localparam int unsigned IdxW = $clog2(RING_DEPTH);
  localparam int unsigned CntW = $clog2(RING_DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam int unsigned EntW = 2 * TIME_BITS;

  // Sequencer states
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_ADD_LO    = 4'd1;
  localparam logic [3:0] ST_ADD_HI    = 4'd2;
  localparam logic [3:0] ST_ADD_EMPTY = 4'd3;
  localparam logic [3:0] ST_ADD_ORDER = 4'd4;
  localparam logic [3:0] ST_ADD_TOUCH = 4'd5;
  localparam logic [3:0] ST_ADD_MERGE = 4'd6;
  localparam logic [3:0] ST_ADV_CHK   = 4'd7;
  localparam logic [3:0] ST_ADV_END   = 4'd8;
  localparam logic [3:0] ST_ADV_POP   = 4'd9;
  localparam logic [3:0] ST_ADV_WAIT  = 4'd10;
  localparam logic [3:0] ST_ADV_CLIP  = 4'd11;
  localparam logic [3:0] ST_EXT       = 4'd12;
  localparam logic [3:0] ST_RST       = 4'd13;
  localparam logic [3:0] ST_FETCH     = 4'd14;
  localparam logic [3:0] ST_DONE      = 4'd15;

  // Ring slot of offset off from base, wrapped once
  function automatic logic [IdxW-1:0] ring_slot(input logic [IdxW-1:0] base,
                                                input logic [CntW-1:0] off);
    logic [SumW-1:0] sum;
    sum = SumW'(base) + SumW'(off);
    if (sum >= SumW'(RING_DEPTH)) begin
      sum = sum - SumW'(RING_DEPTH);
    end
    return sum[IdxW-1:0];
  endfunction

  logic [3:0]           state_q, state_d;
  status_e              st_q, st_d;
  logic [TIME_BITS-1:0] a_q, a_d;
  logic [TIME_BITS-1:0] b_q, b_d;
  logic [TIME_BITS-1:0] first_q, first_d;
  logic [TIME_BITS-1:0] last_q, last_d;
  logic [IdxW-1:0]      head_q, head_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  in_item_t             in_item;
  logic                 in_fire;
  logic                 out_load;
  logic [TIME_BITS-1:0] a_in;
  logic [TIME_BITS-1:0] b_in;

  logic [IdxW-1:0]      front_addr;
  logic [IdxW-1:0]      back_addr;
  logic [IdxW-1:0]      push_addr;
  logic [IdxW-1:0]      head_next;
  logic                 ring_full;

  logic                 ram_we;
  logic [IdxW-1:0]      ram_waddr;
  logic [EntW-1:0]      ram_wdata;
  logic [EntW-1:0]      rd_front;
  logic [EntW-1:0]      rd_back;
  logic [TIME_BITS-1:0] front_left;
  logic [TIME_BITS-1:0] front_right;
  logic [TIME_BITS-1:0] back_left;
  logic [TIME_BITS-1:0] back_right;

  logic [TIME_BITS-1:0] cmp_x;
  logic [TIME_BITS-1:0] cmp_y;
  logic                 cmp_lt;

  // Handshake and input unpacking
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_item       = in_item_t'(s_axis_tdata);
  assign a_in          = TIME_BITS'(in_item.value_a);
  assign b_in          = TIME_BITS'(in_item.value_b);

  // Ring addressing
  assign front_addr = head_q;
  assign back_addr  = (count_q == '0) ? head_q : ring_slot(head_q, count_q - CntW'(1));
  assign push_addr  = ring_slot(head_q, count_q);
  assign head_next  = (head_q == IdxW'(RING_DEPTH - 1)) ? '0 : head_q + IdxW'(1);
  assign ring_full  = (count_q == CntW'(RING_DEPTH));

  // Entry layout: left end low, right end high
  assign front_left  = rd_front[TIME_BITS-1:0];
  assign front_right = rd_front[EntW-1:TIME_BITS];
  assign back_left   = rd_back[TIME_BITS-1:0];
  assign back_right  = rd_back[EntW-1:TIME_BITS];

  bisq_ram #(
    .WIDTH (EntW),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (front_addr),
    .raddr_b_i (back_addr),
    .rdata_a_o (rd_front),
    .rdata_b_o (rd_back)
  );

  // Shared comparator: operand pair picked by the sequencer step
  always_comb begin
    unique case (state_q)
      ST_ADD_LO:    begin cmp_x = a_q;        cmp_y = first_q;     end
      ST_ADD_HI:    begin cmp_x = last_q;     cmp_y = b_q;         end
      ST_ADD_EMPTY: begin cmp_x = a_q;        cmp_y = b_q;         end
      ST_ADD_ORDER: begin cmp_x = a_q;        cmp_y = back_left;   end
      ST_ADD_TOUCH: begin cmp_x = back_right; cmp_y = a_q;         end
      ST_ADD_MERGE: begin cmp_x = back_right; cmp_y = b_q;         end
      ST_ADV_CHK:   begin cmp_x = a_q;        cmp_y = first_q;     end
      ST_ADV_END:   begin cmp_x = a_q;        cmp_y = last_q;      end
      ST_ADV_POP:   begin cmp_x = a_q;        cmp_y = front_right; end
      ST_ADV_CLIP:  begin cmp_x = front_left; cmp_y = a_q;         end
      ST_EXT:       begin cmp_x = a_q;        cmp_y = last_q;      end
      ST_RST:       begin cmp_x = b_q;        cmp_y = a_q;         end
      default:      begin cmp_x = a_q;        cmp_y = b_q;         end
    endcase
  end

  assign cmp_lt = (cmp_x < cmp_y);

  // Sequencer and state updates
  always_comb begin
    state_d   = state_q;
    st_d      = st_q;
    a_d       = a_q;
    b_d       = b_q;
    first_d   = first_q;
    last_d    = last_q;
    head_d    = head_q;
    count_d   = count_q;
    ram_we    = 1'b0;
    ram_waddr = push_addr;
    ram_wdata = {b_q, a_q};
    out_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          a_d   = a_in;
          b_d   = b_in;
          st_d  = STATUS_OK;
          unique case (req_e'(s_axis_tuser))
            REQ_ADD:     state_d = ST_ADD_LO;
            REQ_ADVANCE: state_d = ST_ADV_CHK;
            REQ_EXTEND:  state_d = ST_EXT;
            REQ_RESET:   state_d = ST_RST;
            default:     state_d = ST_IDLE;
          endcase
        end
      end

      // Add: start below domain start
      ST_ADD_LO: begin
        if (cmp_lt) begin
          st_d    = STATUS_INVALID;
          state_d = ST_DONE;
        end else begin
          state_d = ST_ADD_HI;
        end
      end

      // Add: end beyond domain end
      ST_ADD_HI: begin
        if (cmp_lt) begin
          st_d    = STATUS_INVALID;
          state_d = ST_DONE;
        end else begin
          state_d = ST_ADD_EMPTY;
        end
      end

      // Add: empty interval is ignored
      ST_ADD_EMPTY: begin
        state_d = cmp_lt ? ST_ADD_ORDER : ST_DONE;
      end

      // Add: push into an empty ring, or reject a start before the back start
      ST_ADD_ORDER: begin
        if (count_q == '0) begin
          ram_we  = 1'b1;
          count_d = count_q + CntW'(1);
          state_d = ST_FETCH;
        end else if (cmp_lt) begin
          st_d    = STATUS_INVALID;
          state_d = ST_DONE;
        end else begin
          state_d = ST_ADD_TOUCH;
        end
      end

      // Add: gap after the back interval means a push
      ST_ADD_TOUCH: begin
        if (cmp_lt) begin
          if (ring_full) begin
            st_d    = STATUS_FULL;
            state_d = ST_DONE;
          end else begin
            ram_we  = 1'b1;
            count_d = count_q + CntW'(1);
            state_d = ST_FETCH;
          end
        end else begin
          state_d = ST_ADD_MERGE;
        end
      end

      // Add: merge, raising the back right end when the new end is larger
      ST_ADD_MERGE: begin
        if (cmp_lt) begin
          ram_we    = 1'b1;
          ram_waddr = back_addr;
          ram_wdata = {b_q, back_left};
          state_d   = ST_FETCH;
        end else begin
          state_d = ST_DONE;
        end
      end

      // Advance: new start below the current one
      ST_ADV_CHK: begin
        if (cmp_lt) begin
          st_d    = STATUS_INVALID;
          state_d = ST_DONE;
        end else begin
          state_d = ST_ADV_END;
        end
      end

      // Advance: inside the domain pops, else collapse the domain
      ST_ADV_END: begin
        first_d = a_q;
        if (cmp_lt) begin
          state_d = ST_ADV_POP;
        end else begin
          last_d  = a_q;
          head_d  = '0;
          count_d = '0;
          state_d = ST_DONE;
        end
      end

      // Advance: drop the front while it ends at or before the new start
      ST_ADV_POP: begin
        if (count_q == '0) begin
          head_d  = '0;
          state_d = ST_DONE;
        end else if (cmp_lt) begin
          state_d = ST_ADV_CLIP;
        end else begin
          count_d = count_q - CntW'(1);
          head_d  = (count_q == CntW'(1)) ? '0 : head_next;
          state_d = ST_ADV_WAIT;
        end
      end

      // Ring read turnaround after a pop
      ST_ADV_WAIT: begin
        state_d = ST_ADV_POP;
      end

      // Advance: raise the front left end to the new start
      ST_ADV_CLIP: begin
        if (cmp_lt) begin
          ram_we    = 1'b1;
          ram_waddr = front_addr;
          ram_wdata = {front_right, a_q};
        end
        state_d = ST_FETCH;
      end

      // Extend: end may only grow
      ST_EXT: begin
        if (cmp_lt) begin
          st_d = STATUS_INVALID;
        end else begin
          last_d = a_q;
        end
        state_d = ST_DONE;
      end

      // Reset domain: reversed limits rejected
      ST_RST: begin
        if (cmp_lt) begin
          st_d = STATUS_INVALID;
        end else begin
          first_d = a_q;
          last_d  = b_q;
          head_d  = '0;
          count_d = '0;
        end
        state_d = ST_DONE;
      end

      // Ring read turnaround after a write
      ST_FETCH: begin
        state_d = ST_DONE;
      end

      // Register the result once the output stage is free
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result item assembly
  always_comb begin
    out_d                = out_q;
    out_d.pad            = 1'b0;
    out_d.status         = st_q;
    out_d.domain_start   = FIELD_BITS'(first_q);
    out_d.domain_end     = FIELD_BITS'(last_q);
    out_d.interval_count = CNT_OUT_BITS'(count_q);
    if (count_q != '0) begin
      out_d.front_left  = FIELD_BITS'(front_left);
      out_d.front_right = FIELD_BITS'(front_right);
      out_d.back_left   = FIELD_BITS'(back_left);
      out_d.back_right  = FIELD_BITS'(back_right);
    end else begin
      out_d.front_left  = '0;
      out_d.front_right = '0;
      out_d.back_left   = '0;
      out_d.back_right  = '0;
    end
  end

  // Output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_q     <= '0;
      last_q      <= '0;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      last_q      <= last_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    a_q   <= a_d;
    b_q   <= b_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Checks
  `BISQ_ASSERT(a_count_bound, count_q <= CntW'(RING_DEPTH), "ring count above depth")
  `BISQ_ASSERT_IMPL(a_empty_head, count_q == '0, head_q == '0, "empty ring with head off zero")
  `BISQ_ASSERT_NEXT(a_accept_busy, in_fire, state_q != ST_IDLE, "accepted item left no work")
  `BISQ_ASSERT_IMPL(a_merge_nonempty, state_q == ST_ADD_MERGE, count_q != '0,
                    "merge step with empty ring")

endmodule

FILE: sv/bisq_ram.sv
// Generic RAM: one write port, two registered read ports, read-first.
module bisq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(DEPTH)-1:0]       waddr_i,
  input  logic [WIDTH-1:0]               wdata_i,
  input  logic [$clog2(DEPTH)-1:0]       raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0]       raddr_b_i,
  output logic [WIDTH-1:0]               rdata_a_o,
  output logic [WIDTH-1:0]               rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write and registered reads; a read at the written address returns old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the Boolean interval signal queue.
`timescale 1ns / 100ps

module tb_top;
  import bisq_pkg::*;

  localparam int unsigned DEPTH         = RING_DEPTH_DEF;
  localparam int unsigned DIRECTED_REQS = 25;
  localparam int unsigned RANDOM_REQS   = 1200;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_CYCLES  = 60;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam longint unsigned TMAX      = 64'hFFFF_FFFF;

  typedef struct {
    req_e     kind;
    in_item_t data;
  } req_item_t;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  // value_a [31:0], value_b [63:32]
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
  // req_type [1:0]
  logic [IN_TUSER_BITS-1:0]  s_axis_tuser  = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  // status, domain_start, domain_end, interval_count, front_left, front_right,
  // back_left, back_right, zero pad
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

  boolean_interval_signal_queue i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Pending requests and the state reports they should produce
  req_item_t  request_q[$];
  out_item_t  state_report_q[$];
  req_item_t  issue_req;
  out_item_t  got_report;
  out_item_t  want_report;

  int unsigned cycle_cnt     = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatch_count = 0;
  int unsigned live_items    = 0;
  int unsigned hold_left     = 0;
  bit          hold_done     = 1'b0;

  // No idling on either side while this window of results goes by
  wire calm    = (results_seen >= 600) && (results_seen < 800);
  wire holding = (hold_left != 0);

  // ---------------------------------------------------------------------------
  // Predictor: domain limits and a ring of true intervals
  // ---------------------------------------------------------------------------
  logic [31:0] dom_lo = '0;
  logic [31:0] dom_hi = '0;
  logic [31:0] ivl_lo[DEPTH];
  logic [31:0] ivl_hi[DEPTH];
  int unsigned ring_head = 0;
  int unsigned ring_cnt  = 0;

  function automatic status_e apply_add(logic [31:0] a, logic [31:0] b);
    int unsigned bi;
    if (a < dom_lo || b > dom_hi) return STATUS_INVALID;
    if (a >= b) return STATUS_OK;
    if (ring_cnt > 0) begin
      bi = (ring_head + ring_cnt - 1) % DEPTH;
      if (ivl_lo[bi] > a) return STATUS_INVALID;
      // overlapping or touching: widen the newest interval
      if (a <= ivl_hi[bi]) begin
        if (b > ivl_hi[bi]) ivl_hi[bi] = b;
        return STATUS_OK;
      end
    end
    if (ring_cnt >= DEPTH) return STATUS_FULL;
    bi = (ring_head + ring_cnt) % DEPTH;
    ivl_lo[bi] = a;
    ivl_hi[bi] = b;
    ring_cnt++;
    return STATUS_OK;
  endfunction

  function automatic status_e apply_advance(logic [31:0] nf);
    if (nf < dom_lo) return STATUS_INVALID;
    if (nf >= dom_hi) begin
      dom_lo    = nf;
      dom_hi    = nf;
      ring_head = 0;
      ring_cnt  = 0;
      return STATUS_OK;
    end
    dom_lo = nf;
    // drop intervals that ended, then clip the survivor at the front
    while (ring_cnt > 0 && ivl_hi[ring_head] <= nf) begin
      ring_head = (ring_head + 1) % DEPTH;
      ring_cnt--;
    end
    if (ring_cnt == 0) ring_head = 0;
    else if (ivl_lo[ring_head] < nf) ivl_lo[ring_head] = nf;
    return STATUS_OK;
  endfunction

  function automatic out_item_t predict_state_report(req_e kind, logic [31:0] a,
                                                     logic [31:0] b);
    out_item_t   rep;
    int unsigned bi;
    rep = '0;
    case (kind)
      REQ_ADD:     rep.status = apply_add(a, b);
      REQ_ADVANCE: rep.status = apply_advance(a);
      REQ_EXTEND: begin
        if (a < dom_hi) begin
          rep.status = STATUS_INVALID;
        end else begin
          dom_hi     = a;
          rep.status = STATUS_OK;
        end
      end
      REQ_RESET: begin
        if (a > b) begin
          rep.status = STATUS_INVALID;
        end else begin
          dom_lo     = a;
          dom_hi     = b;
          ring_head  = 0;
          ring_cnt   = 0;
          rep.status = STATUS_OK;
        end
      end
    endcase
    rep.domain_start   = dom_lo;
    rep.domain_end     = dom_hi;
    rep.interval_count = CNT_OUT_BITS'(ring_cnt);
    if (ring_cnt > 0) begin
      bi = (ring_head + ring_cnt - 1) % DEPTH;
      rep.front_left  = ivl_lo[ring_head];
      rep.front_right = ivl_hi[ring_head];
      rep.back_left   = ivl_lo[bi];
      rep.back_right  = ivl_hi[bi];
    end
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  // rough view of the domain, used only to steer requests into useful places
  longint unsigned gen_lo, gen_hi, gen_end, gen_back;

  function automatic longint unsigned rand_upto(longint unsigned n);
    if (n >= TMAX) return $urandom;
    return $urandom_range(n[31:0], 0);
  endfunction

  function automatic longint unsigned clip32(longint unsigned v);
    return (v > TMAX) ? TMAX : v;
  endfunction

  task automatic push_req(req_e kind, longint unsigned a, longint unsigned b);
    req_item_t item;
    item.kind         = kind;
    item.data.value_a = a[31:0];
    item.data.value_b = b[31:0];
    request_q.insert(request_q.size(), item);
    // empty adds do nothing, so they do not count
    if (!(kind == REQ_ADD && a[31:0] >= b[31:0])) live_items++;
  endtask

  task automatic push_noise();
    longint unsigned a, b;
    a = $urandom;
    b = $urandom_range(1) ? longint'($urandom) : clip32(a + $urandom_range(1000));
    push_req(req_e'($urandom_range(3)), a, b);
  endtask

  // Reset a domain, then a run of mostly well-formed adds, advances and extends
  task automatic make_episode();
    longint unsigned span, unit, a, b, nf;
    int unsigned     n, pick;
    bit              fill;
    case ($urandom_range(3))
      0:       span = $urandom_range(400, 40);
      1:       span = $urandom_range(50000, 400);
      2:       span = rand_upto(TMAX);
      default: span = TMAX;
    endcase
    case ($urandom_range(2))
      0:       gen_lo = 0;
      1:       gen_lo = TMAX - span;
      default: gen_lo = rand_upto(TMAX - span);
    endcase
    gen_hi   = gen_lo + span;
    gen_end  = gen_lo;
    gen_back = gen_lo;
    unit     = span / 64;
    if (unit < 3) unit = 3;
    // fill runs push separated intervals until the ring overflows
    fill = ($urandom_range(4) == 0);
    push_req(REQ_RESET, gen_lo, gen_hi);
    n = fill ? $urandom_range(24, 17) : $urandom_range(30, 1);
    repeat (n) begin
      pick = fill ? 0 : $urandom_range(99);
      if (pick < 60) begin
        if (!fill && $urandom_range(5) == 0) a = gen_end - rand_upto(gen_end - gen_back);
        else a = gen_end + 1 + rand_upto(unit);
        b = a + 1 + rand_upto(unit);
        if (b > gen_hi) begin
          if (gen_hi < TMAX && $urandom_range(1)) begin
            gen_hi = clip32(b + rand_upto(unit));
            push_req(REQ_EXTEND, gen_hi, $urandom);
          end
          if (b > gen_hi) b = gen_hi;
        end
        push_req(REQ_ADD, a, b);
        if (a < b && a <= TMAX) begin
          if (a > gen_end) gen_back = a;
          if (b > gen_end) gen_end = b;
        end
      end else if (pick < 75) begin
        if ($urandom_range(1))
          nf = gen_end - rand_upto((gen_end - gen_lo > unit) ? unit : gen_end - gen_lo);
        else
          nf = clip32(gen_lo + rand_upto(gen_end - gen_lo + 2));
        push_req(REQ_ADVANCE, nf, $urandom);
        gen_lo = nf;
        if (nf >= gen_hi) gen_hi = nf;
        if (nf > gen_end) gen_end = nf;
        if (nf > gen_back) gen_back = nf;
      end else if (pick < 85) begin
        gen_hi = clip32(gen_hi + rand_upto(unit));
        push_req(REQ_EXTEND, gen_hi, $urandom);
      end else if (pick < 93) begin
        // broken requests that must leave the state alone
        case ($urandom_range(3))
          0:       push_req(REQ_ADD, gen_back - 1, gen_back + 1);
          1:       push_req(REQ_ADD, gen_end + 1, gen_hi + 1);
          2:       push_req(REQ_ADVANCE, gen_lo - 1, $urandom);
          default: push_req(REQ_EXTEND, gen_hi - 1, $urandom);
        endcase
      end else begin
        a = gen_lo + rand_upto(gen_hi - gen_lo);
        push_req(REQ_ADD, a, a);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Driver: one request offered at a time, held until accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        state_report_q.insert(state_report_q.size(),
                              predict_state_report(req_e'(s_axis_tuser),
                                                   s_axis_tdata[31:0],
                                                   s_axis_tdata[63:32]));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (request_q.size() > 0 && (calm || $urandom_range(99) >= 33)) begin
          issue_req = request_q[0];
          request_q.delete(0);
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= issue_req.kind;
          s_axis_tdata  <= issue_req.data;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus one long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= !holding && (calm || $urandom_range(99) >= 33);
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 300) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and checker
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch at result %0d: %s expected %0h got %0h",
               results_seen, what, want_v, got_v);
  endtask

  task automatic check_field(string what, logic [31:0] got_v, logic [31:0] want_v);
    if (got_v !== want_v) report_mismatch(what, want_v, got_v);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      got_report = out_item_t'(m_axis_tdata);
      if (state_report_q.size() == 0) begin
        report_mismatch("result with no request pending", '0, 32'(got_report.status));
      end else begin
        want_report = state_report_q[0];
        state_report_q.delete(0);
        check_field("status", 32'(got_report.status), 32'(want_report.status));
        check_field("domain_start", got_report.domain_start, want_report.domain_start);
        check_field("domain_end", got_report.domain_end, want_report.domain_end);
        check_field("interval_count", 32'(got_report.interval_count),
                    32'(want_report.interval_count));
        check_field("front_left", got_report.front_left, want_report.front_left);
        check_field("front_right", got_report.front_right, want_report.front_right);
        check_field("back_left", got_report.back_left, want_report.back_left);
        check_field("back_right", got_report.back_right, want_report.back_right);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build stimulus, reset, drain, verdict
  // ---------------------------------------------------------------------------
  initial begin
    // empty domain at reset: empty add, add outside, reversed reset, extend in place
    push_req(REQ_ADD, 0, 0);
    push_req(REQ_ADD, 0, 1);
    push_req(REQ_RESET, 10, 5);
    push_req(REQ_EXTEND, 0, TMAX);
    // full-range domain: push, touch, overlap, out-of-order and empty adds
    push_req(REQ_RESET, 0, TMAX);
    push_req(REQ_ADD, 0, 10);
    push_req(REQ_ADD, 10, 20);
    push_req(REQ_ADD, 15, 30);
    push_req(REQ_ADD, 40, 50);
    push_req(REQ_ADD, 35, 45);
    push_req(REQ_ADD, 60, 60);
    push_req(REQ_ADD, 64'hFFFF_FFF0, TMAX);
    push_req(REQ_ADD, TMAX, TMAX);
    // advance with clip, with pop and clip, backwards; extend backwards
    push_req(REQ_ADVANCE, 5, 0);
    push_req(REQ_ADVANCE, 45, TMAX);
    push_req(REQ_ADVANCE, 3, 0);
    push_req(REQ_EXTEND, 100, 0);
    // point domain, then grow it and advance past its end
    push_req(REQ_RESET, 100, 100);
    push_req(REQ_ADD, 100, 101);
    push_req(REQ_EXTEND, 200, 0);
    push_req(REQ_ADD, 120, 130);
    push_req(REQ_ADD, 90, 95);
    push_req(REQ_ADVANCE, 300, 0);
    push_req(REQ_ADVANCE, 300, 0);
    push_req(REQ_RESET, TMAX, TMAX);

    while (live_items < DIRECTED_REQS + RANDOM_REQS) begin
      if ($urandom_range(99) < 75) make_episode();
      else repeat ($urandom_range(3, 1)) push_noise();
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (state_report_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && state_report_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
